[design/fsra_pkg.sv]
package fsra_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [31:0] RegionFirstBase = 32'h0002_0000;
  localparam logic [31:0] RegionStride    = 32'h0000_1000;
  localparam logic [31:0] AllOnes32       = 32'hFFFF_FFFF;

  typedef logic [SlotIdxW-1:0] slot_idx_t;

  typedef enum logic [1:0] {
    OpMap     = 2'd0,
    OpUnmap   = 2'd1,
    OpProtect = 2'd2
  } fsra_op_e;

  // One commit to the slot table
  typedef struct packed {
    logic        set_used;
    logic        clr_used;
    logic        wr_len;
    logic        wr_prot;
    slot_idx_t   idx;
    logic [31:0] len;
    logic [7:0]  prot;
  } fsra_upd_t;

  function automatic logic [31:0] slot_base(slot_idx_t idx);
    return RegionFirstBase + 32'(idx) * RegionStride;
  endfunction

endpackage

[design/fsra_if.sv]
interface fsra_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] region_address;
  logic [31:0] region_length;
  logic [7:0]  protection;

  modport source (output valid, opcode, region_address, region_length, protection,
                  input ready);
  modport sink   (input valid, opcode, region_address, region_length, protection,
                  output ready);
endinterface

interface fsra_rsp_if;
  logic        valid;
  logic        ready;
  logic        failed;
  logic [31:0] mapped_address;
  logic [3:0]  slot_index;

  modport source (output valid, failed, mapped_address, slot_index, input ready);
  modport sink   (input valid, failed, mapped_address, slot_index, output ready);
endinterface

[design/fsra_slot_table.sv]
module fsra_slot_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsra_pkg::slot_idx_t rd_idx_i,
  output logic                rd_used_o,
  input  fsra_pkg::fsra_upd_t upd_i
);
  import fsra_pkg::*;

  logic [SLOTS-1:0] used_q;
  logic [SLOTS-1:0] used_d;
  logic [31:0]      len_mem [SLOTS];
  logic [7:0]       prot_mem [SLOTS];

  assign rd_used_o = used_q[rd_idx_i];

  always_comb begin
    used_d = used_q;
    if (upd_i.set_used) begin
      used_d[upd_i.idx] = 1'b1;
    end else if (upd_i.clr_used) begin
      used_d[upd_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // length and protection: written only, undefined until written
  always_ff @(posedge clk_i) begin
    if (upd_i.wr_len) begin
      len_mem[upd_i.idx] <= upd_i.len;
    end
    if (upd_i.wr_prot) begin
      prot_mem[upd_i.idx] <= upd_i.prot;
    end
  end

endmodule

[design/fixed_slot_region_allocator.sv]
// First-fit region allocator over SLOTS fixed slots.
// Slot i always covers the region based at 0x20000 + i * 0x1000.
// req_i (sink): one beat per request. opcode selects map, unmap or protect;
//   map ignores region_address, unmap/protect ignore region_length.
// rsp_o (source): exactly one beat per request, in request order, carrying
//   failed, mapped_address and slot_index.
// A single compare unit walks the slot table one slot per cycle, starting
// at slot 0, and stops at the first hit (lowest free slot for map, used
// slot whose base matches for unmap/protect) or after the last slot.
// A new request is taken only after the previous scan has committed and
// the sequencer is back in idle, so two scans never overlap.
// The response sits in an output register; the next request may be taken
// and scanned while it waits. If the receiver still stalls when the next
// scan finishes, the scan holds at its final slot and commits nothing
// until the output register frees up.
// Reset clears all used marks, the sequencer and the output valid; no
// clearing pass is needed, the block is ready right after reset.
module fixed_slot_region_allocator (
  input  logic    clk_i,
  input  logic    rst_ni,
  fsra_req_if.sink   req_i,
  fsra_rsp_if.source rsp_o
);
  import fsra_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic state_q, state_d;

  // latched request
  logic [1:0]  op_q;
  logic [31:0] addr_q;
  logic [31:0] len_q;
  logic [7:0]  prot_q;

  slot_idx_t idx_q, idx_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        out_failed_q;
  logic [31:0] out_addr_q;
  logic [3:0]  out_sidx_q;

  logic        used;
  logic        hit;
  logic        last;
  logic        out_free;
  logic        commit;
  logic [31:0] base;
  fsra_upd_t   upd;

  fsra_slot_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (idx_q),
    .rd_used_o (used),
    .upd_i     (upd)
  );

  assign req_i.ready = (state_q == StIdle);

  // shared compare unit: one slot per cycle
  assign base = slot_base(idx_q);

  always_comb begin
    case (op_q) inside
      OpMap:              hit = !used;
      OpUnmap, OpProtect: hit = used && (base == addr_q);
      default:            hit = 1'b0;
    endcase
  end

  assign last     = (idx_q == SlotIdxW'(SLOTS - 1));
  assign out_free = !out_valid_q || rsp_o.ready;
  assign commit   = (state_q == StScan) && (hit || last) && out_free;

  always_comb begin
    upd          = '0;
    upd.idx      = idx_q;
    upd.len      = len_q;
    upd.prot     = prot_q;
    if (commit && hit) begin
      case (op_q) inside
        OpMap: begin
          upd.set_used = 1'b1;
          upd.wr_len   = 1'b1;
          upd.wr_prot  = 1'b1;
        end
        OpUnmap:   upd.clr_used = 1'b1;
        OpProtect: upd.wr_prot  = 1'b1;
        default:   upd.set_used = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          state_d = StScan;
          idx_d   = '0;
        end
      end
      StScan: begin
        if (commit) begin
          state_d = StIdle;
        end else if (!(hit || last)) begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q   <= req_i.opcode;
      addr_q <= req_i.region_address;
      len_q  <= req_i.region_length;
      prot_q <= req_i.protection;
    end
    if (commit) begin
      out_failed_q <= !hit;
      out_sidx_q   <= hit ? 4'(idx_q) : 4'd0;
      if (op_q == OpMap) begin
        out_addr_q <= hit ? base : AllOnes32;
      end else begin
        out_addr_q <= '0;
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.failed         = out_failed_q;
  assign rsp_o.mapped_address = out_addr_q;
  assign rsp_o.slot_index     = out_sidx_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fsra_pkg::*;

  // Opcode 3 has no meaning in the block; it must fail without side effects
  localparam logic [1:0] OpUndefined = 2'd3;

  // Clock edges waited after the last expected reply, before the run is closed
  localparam int unsigned DrainCycles = 40;
  // Long receiver stall used to back the block up into its request port
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned HoldOffAt = 120;
  localparam int unsigned RandomBurst = 20;
  localparam int unsigned TotalRequests = 400;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] len;
    logic [7:0]  prot;
  } region_request_t;

  typedef struct {
    logic        failed;
    logic [31:0] mapped_address;
    logic [3:0]  slot_index;
  } region_reply_t;

  logic clk_i;
  logic rst_ni;

  fsra_req_if req_if ();
  fsra_rsp_if rsp_if ();

  fixed_slot_region_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow of the slot table. Lengths and protections are never returned,
  // but they are kept so the shadow follows every write the block does.
  logic        slot_taken [SLOTS];
  logic [31:0] slot_len   [SLOTS];
  logic [7:0]  slot_prot  [SLOTS];

  region_request_t pending_requests [$];
  region_reply_t   expected_replies [$];

  int unsigned n_total;
  int unsigned n_accepted;
  int unsigned n_errors;
  int unsigned hold_left;
  logic        hold_done;

  always #5 clk_i = ~clk_i;

  // Base address of slot n; slot SLOTS is the first address past the table
  function automatic logic [31:0] base_of(int unsigned n);
    return RegionFirstBase + RegionStride * 32'(n);
  endfunction

  // First-fit allocation on map; unmap/protect hit the lowest used slot
  // whose base equals the address. Anything else fails with no change.
  function automatic region_reply_t allocate_or_release(region_request_t rq);
    region_reply_t r;
    int            hit;
    r.failed         = 1'b1;
    r.mapped_address = '0;
    r.slot_index     = '0;
    hit              = -1;
    case (rq.op)
      OpMap: begin
        r.mapped_address = AllOnes32;
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && !slot_taken[i]) hit = i;
        end
        if (hit >= 0) begin
          slot_taken[hit]  = 1'b1;
          slot_len[hit]    = rq.len;
          slot_prot[hit]   = rq.prot;
          r.failed         = 1'b0;
          r.mapped_address = base_of(hit);
          r.slot_index     = 4'(hit);
        end
      end
      OpUnmap, OpProtect: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && slot_taken[i] && base_of(i) == rq.addr) hit = i;
        end
        if (hit >= 0) begin
          if (rq.op == OpUnmap) slot_taken[hit] = 1'b0;
          else slot_prot[hit] = rq.prot;
          r.failed     = 1'b0;
          r.slot_index = 4'(hit);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_request(logic [1:0] op, logic [31:0] addr, logic [31:0] len,
                               logic [7:0] prot);
    region_request_t rq;
    rq.op   = op;
    rq.addr = addr;
    rq.len  = len;
    rq.prot = prot;
    pending_requests.push_back(rq);
  endtask

  // Mostly exact slot bases, so unmap/protect often hit; the rest are
  // unaligned, just outside the table, or anywhere in the address space.
  function automatic logic [31:0] pick_address();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return base_of($urandom_range(SLOTS - 1));
    if (k < 80) return base_of($urandom_range(SLOTS - 1)) + $urandom_range(1, 32'hFFF);
    if (k < 85) return ($urandom_range(1) != 0) ? base_of(SLOTS) : RegionFirstBase - RegionStride;
    return $urandom();
  endfunction

  // Three idling regimes, in order, across the accepted requests
  function automatic int unsigned idle_stage();
    return (n_accepted * 3) / n_total;
  endfunction

  // Request driver: presents the next queued request, holds it until taken,
  // and feeds every accepted beat through the shadow table.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    region_request_t nxt;
    region_request_t taken;
    int unsigned     idle_pct;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken.op   = req_if.opcode;
        taken.addr = req_if.region_address;
        taken.len  = req_if.region_length;
        taken.prot = req_if.protection;
        expected_replies.push_back(allocate_or_release(taken));
        n_accepted <= n_accepted + 1;
      end
      case (idle_stage())
        0:       idle_pct = 20;
        1:       idle_pct = 65;
        default: idle_pct = 0;
      endcase
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_requests.pop_front();
          req_if.valid          <= 1'b1;
          req_if.opcode         <= nxt.op;
          req_if.region_address <= nxt.addr;
          req_if.region_length  <= nxt.len;
          req_if.protection     <= nxt.prot;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver stall, early in the run, while the sender keeps going
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted == HoldOffAt) begin
      hold_left <= HoldOffCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Reply monitor: every reply beat is matched against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : check_replies
    region_reply_t want;
    int unsigned   idle_pct;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply failed=%0b address=%h slot=%0d", $time,
                   rsp_if.failed, rsp_if.mapped_address, rsp_if.slot_index);
          n_errors++;
        end else begin
          want = expected_replies.pop_front();
          if (rsp_if.failed !== want.failed) begin
            $display("%0t: failed expected %0b actual %0b", $time, want.failed,
                     rsp_if.failed);
            n_errors++;
          end
          if (rsp_if.mapped_address !== want.mapped_address) begin
            $display("%0t: mapped_address expected %h actual %h", $time,
                     want.mapped_address, rsp_if.mapped_address);
            n_errors++;
          end
          if (rsp_if.slot_index !== want.slot_index) begin
            $display("%0t: slot_index expected %0d actual %0d", $time, want.slot_index,
                     rsp_if.slot_index);
            n_errors++;
          end
        end
      end
      case (idle_stage())
        0:       idle_pct = 65;
        1:       idle_pct = 20;
        default: idle_pct = 0;
      endcase
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin : stimulus
    int unsigned map_pct;
    int unsigned k;
    logic [1:0]  op;

    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.opcode         = '0;
    req_if.region_address = '0;
    req_if.region_length  = '0;
    req_if.protection     = '0;
    rsp_if.ready          = 1'b0;
    n_accepted            = 0;
    n_errors              = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_taken[i] = 1'b0;
      slot_len[i]   = '0;
      slot_prot[i]  = '0;
    end

    // Directed: undefined opcode, misses on an empty table, fill to the
    // last slot with extreme lengths and protections, then a map on a full
    // table, bad addresses, a release and a reuse of the released slot.
    queue_request(OpUndefined, '1, '1, '1);
    queue_request(OpUnmap, RegionFirstBase, '0, '0);
    queue_request(OpProtect, RegionFirstBase, '1, 8'hFF);
    for (int i = 0; i < SLOTS; i++) begin
      queue_request(OpMap, (i % 2) ? '1 : '0, (i % 2) ? '0 : '1, (i % 2) ? 8'hFF : 8'h00);
    end
    queue_request(OpMap, '0, 32'h0000_1000, 8'h5A);
    queue_request(OpProtect, base_of(SLOTS - 1), '1, 8'hA5);
    queue_request(OpUnmap, RegionFirstBase + 32'd1, '0, '0);
    queue_request(OpUnmap, '1, '0, '0);
    queue_request(OpUnmap, base_of(SLOTS), '0, '0);
    queue_request(OpUnmap, base_of(5), '1, '0);
    queue_request(OpMap, '1, 32'h8000_0000, 8'h80);

    // Random: bursts with a random map bias, so the table swings between
    // full and empty and both hits and misses keep coming.
    map_pct = 50;
    for (int n = pending_requests.size(); n < TotalRequests; n++) begin
      if (n % RandomBurst == 0) map_pct = $urandom_range(10, 90);
      k = $urandom_range(99);
      if (k < map_pct) op = OpMap;
      else if ($urandom_range(99) < 5) op = OpUndefined;
      else if ($urandom_range(99) < 55) op = OpUnmap;
      else op = OpProtect;
      queue_request(op, pick_address(), $urandom(), 8'($urandom_range(255)));
    end
    n_total = pending_requests.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_total) @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
    // Give any stray reply time to show
    repeat (DrainCycles) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard, many times the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
